// ===== rtl/iecw_pkg.sv =====
// Shared types and constants for the information-element channel width parser.
// No dependencies; the register stages, the element walker and the top level import this package.
`default_nettype none

package iecw_pkg;

  // Element ids and HT operation bit fields
  localparam logic [7:0] HT_OP_ID       = 8'd61;
  localparam logic [7:0] VHT_OP_ID      = 8'd192;
  localparam logic [7:0] HT_OFFSET_MASK = 8'h03;
  localparam logic [7:0] HT_WIDE_BIT    = 8'h04;

  // VHT channel width field values
  localparam logic [7:0] VHT_CW_20_40  = 8'd0;
  localparam logic [7:0] VHT_CW_80     = 8'd1;
  localparam logic [7:0] VHT_CW_160    = 8'd2;
  localparam logic [7:0] VHT_CW_80P80  = 8'd3;

  // Width codes on the result channel
  typedef enum logic [2:0] {
    W_NONE = 3'd0,
    W_20   = 3'd1,
    W_40   = 3'd2,
    W_80   = 3'd3,
    W_160  = 3'd4
  } width_t;

  // Kind of element being walked
  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_HT    = 2'd1,
    KIND_VHT   = 2'd2
  } kind_t;

  // One input beat held in the input register
  typedef struct packed {
    logic [7:0] ie_byte;
    logic       last_byte;
  } item_t;

  // Result handed from the parser to the output register
  typedef struct packed {
    logic   valid;
    width_t width;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/iecw_if.sv =====
// Valid/ready channel interfaces for the byte input and the width result.
// Depends on nothing; used by the top level and its input and result registers.
`default_nettype none

interface iecw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ie_byte;
  logic       last_byte;

  modport source (output valid, output ie_byte, output last_byte, input ready);
  modport sink   (input valid, input ie_byte, input last_byte, output ready);
endinterface

interface iecw_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] width_code;

  modport source (output valid, output width_code, input ready);
  modport sink   (input valid, input width_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/iecw_in_stage.sv =====
// Input register: captures one byte beat and holds it until the parser takes it.
// Depends on iecw_pkg and iecw_in_if.
`default_nettype none

module iecw_in_stage
  import iecw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  iecw_in_if.sink   in_ch,
  input  wire logic adv,       // parser consumes the held beat this cycle
  output logic      hold_valid,
  output item_t     hold_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Free slot or slot draining this cycle
  assign in_ch.ready = !valid_r || adv;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.ie_byte   <= in_ch.ie_byte;
      item_r.last_byte <= in_ch.last_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

`default_nettype wire

// ===== rtl/iecw_parser.sv =====
// Element walker: id/length/body state and width tracking, one byte per step.
// Depends on iecw_pkg.
`default_nettype none

module iecw_parser
  import iecw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,     // one byte processed this cycle
  input  item_t     item,
  output res_t      res
);

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  kind_t      kind_r, kind_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  width_t     comm_r, comm_nxt;
  width_t     pend_r, pend_nxt;
  logic       pv_r, pv_nxt;
  logic [7:0] b;
  logic       done;

  assign b = item.ie_byte;

  // Next state for one byte
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    comm_nxt  = comm_r;
    pend_nxt  = pend_r;
    pv_nxt    = pv_r;
    done      = 1'b0;

    unique case (phase_r)
      PH_LEN: begin
        len_nxt = b;
        cnt_nxt = '0;
        if (b == 8'd0) begin
          done = 1'b1;
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        if (kind_r == KIND_HT && cnt_r == 8'd1 && len_r >= 8'd2) begin
          pend_nxt = (((b & HT_WIDE_BIT) != 8'd0) && ((b & HT_OFFSET_MASK) != 8'd0))
                     ? W_40 : W_20;
          pv_nxt   = 1'b1;
        end else if (kind_r == KIND_VHT && cnt_r == 8'd0) begin
          unique case (b) inside
            VHT_CW_20_40: begin
              pend_nxt = (comm_r > W_40) ? comm_r : W_40;
              pv_nxt   = 1'b1;
            end
            VHT_CW_80: begin
              pend_nxt = W_80;
              pv_nxt   = 1'b1;
            end
            VHT_CW_160, VHT_CW_80P80: begin
              pend_nxt = W_160;
              pv_nxt   = 1'b1;
            end
            default: ;
          endcase
        end
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_nxt >= len_r) begin
          done = 1'b1;
        end
      end
      default: begin
        // Expect id (unused phase code handled the same way)
        if (b == HT_OP_ID) begin
          kind_nxt = KIND_HT;
        end else if (b == VHT_OP_ID) begin
          kind_nxt = KIND_VHT;
        end else begin
          kind_nxt = KIND_OTHER;
        end
        pv_nxt    = 1'b0;
        pend_nxt  = W_NONE;
        phase_nxt = PH_LEN;
      end
    endcase

    // Element complete: commit pending update
    if (done) begin
      if (pv_nxt) begin
        comm_nxt = pend_nxt;
      end
      pv_nxt    = 1'b0;
      pend_nxt  = W_NONE;
      kind_nxt  = KIND_OTHER;
      len_nxt   = '0;
      cnt_nxt   = '0;
      phase_nxt = PH_ID;
    end
  end

  // Result on the final byte, taken after this byte's commit
  assign res.valid = step && item.last_byte;
  assign res.width = comm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      phase_r <= PH_ID;
      kind_r  <= KIND_OTHER;
      len_r   <= '0;
      cnt_r   <= '0;
      comm_r  <= W_NONE;
      pend_r  <= W_NONE;
      pv_r    <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      comm_r  <= comm_nxt;
      pend_r  <= pend_nxt;
      pv_r    <= pv_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iecw_out_stage.sv =====
// Result register: holds the width code until the sink takes the beat.
// Depends on iecw_pkg and iecw_out_if.
`default_nettype none

module iecw_out_stage
  import iecw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  res_t       res,
  output logic       room,     // a new result can be loaded this cycle
  iecw_out_if.source out_ch
);

  logic   valid_r, valid_nxt;
  width_t width_r;

  assign room = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      width_r <= res.width;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.width_code = width_r;

endmodule

`default_nettype wire

// ===== rtl/ie_channel_width_parser_core.sv =====
// A final byte passes from the input register through the element walker into the result register.
// Throughput: one byte per cycle; a non-final byte never waits on the result side.
// A final byte waits in the input register only while the result register is full
// and not being taken.
// Reset (synchronous, active low) empties both registers and clears the parse state.
// Top level: input register, element walker, result register. Depends on iecw_pkg, iecw_if.
`default_nettype none

module ie_channel_width_parser_core
  import iecw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  iecw_in_if.sink    in_ch,
  iecw_out_if.source out_ch
);

  logic  hold_valid;
  item_t hold_item;
  logic  room;
  logic  adv;
  res_t  res;

  // Non-final bytes always move; a final byte needs room for its result
  assign adv = hold_valid && (!hold_item.last_byte || room);

  iecw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .adv        (adv),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  iecw_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (hold_item),
    .res   (res)
  );

  iecw_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/iecw_checker.sv =====
// Port-level checks for the channel width parser, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module iecw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_width
);

  // A waiting result beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_width))
    else $error("result beat changed while stalled");

  // Only defined width codes leave the block
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_width <= 3'd4))
    else $error("width code out of range");

  // A fresh result follows an accepted final byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a final byte");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ie_channel_width_parser_core iecw_checker u_iecw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_width (out_ch.width_code)
);

`default_nettype wire
